FILE: design/ps2ma_pkg.sv
// Package for the PS/2 mouse packet accumulator: types, constants and arithmetic helpers.
package ps2ma_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int GAIN_W   = 13;
    localparam int SUM_W    = 16;
    localparam int DELTA_W  = 8;
    localparam int BTN_W    = 3;
    localparam int CURSOR_W = 15;
    localparam int PROD_W   = DELTA_W + GAIN_W + 1;
    localparam int POSSUM_W = PROD_W + 1;
    localparam int OUT_W    = 56;

    // Reset values
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 13'd512;
    localparam logic [CURSOR_W-1:0] CURSOR_RESET = 15'd16384;

    // Header byte bit positions
    localparam int HDR_ALWAYS_ONE = 3;
    localparam int HDR_X_SIGN     = 4;
    localparam int HDR_Y_SIGN     = 5;

    // Word kind carried on tuser
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_POLL = 1'b1
    } t_op;

    // Position of the next mouse byte within a three-byte packet
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_X      = 2'd1,
        PH_Y      = 2'd2
    } t_phase;

    // Saturate a 17-bit signed sum to 16 bits
    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W:0] v);
        logic [SUM_W-1:0] r;
        if (v[SUM_W] != v[SUM_W-1]) begin
            r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

    // Clamp a 16-bit signed accumulator to -128..127
    function automatic logic [DELTA_W-1:0] clamp_delta(input logic signed [SUM_W-1:0] v);
        logic [DELTA_W-1:0] r;
        if (v > 16'sd127) begin
            r = 8'h7F;
        end else if (v < -16'sd128) begin
            r = 8'h80;
        end else begin
            r = v[DELTA_W-1:0];
        end
        return r;
    endfunction

    // Clamp a signed position sum to 0..32767
    function automatic logic [CURSOR_W-1:0] clamp_cursor(
        input logic signed [POSSUM_W-1:0] v
    );
        logic [CURSOR_W-1:0] r;
        if (v[POSSUM_W-1]) begin
            r = '0;
        end else if (v[POSSUM_W-2:CURSOR_W] != '0) begin
            r = '1;
        end else begin
            r = v[CURSOR_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: design/ps2_mouse_packet_accumulator.sv
// Top level of the PS/2 mouse packet accumulator: input register, packet logic, result register.
//
//  channel    | direction | fields (lowest bit first)
//  -----------+-----------+------------------------------------------------------------
//  s_axis     | in        | tuser: operation; tdata: data_byte
//  m_axis     | out       | tdata: delta_x, delta_y, buttons, position_x, position_y, zero pad
//  cfg write  | in        | i_cfg_wr_data: position_gain
//
// One word is taken per cycle unless the result register stalls; a poll result reaches m_axis
// through the input register, then the result register.
// Reset clears the packet state and accumulators, sets both cursors to 16384 and the gain to 512.
// When the result register is full and not read, the input register holds its word and
// s_axis_tready falls; the result register is the only stall point.
module ps2_mouse_packet_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ps2ma_pkg::BYTE_W-1:0]      s_axis_tdata,   // data_byte
    input  logic                              s_axis_tuser,   // operation
    // Master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ps2ma_pkg::OUT_W-1:0]       m_axis_tdata,   // delta_x, delta_y, buttons,
                                                              // position_x, position_y, pad
    // Configuration
    input  logic                              i_cfg_wr_en,
    input  logic [ps2ma_pkg::GAIN_W-1:0]      i_cfg_wr_data   // position_gain
);

    // Input register
    logic                              r_in_valid;
    ps2ma_pkg::t_op                    r_in_op;
    logic [ps2ma_pkg::BYTE_W-1:0]      r_in_byte;

    // Packet and accumulator state
    ps2ma_pkg::t_phase                 r_phase, n_phase;
    logic [ps2ma_pkg::BYTE_W-1:0]      r_header, n_header;
    logic [ps2ma_pkg::BYTE_W-1:0]      r_x_byte, n_x_byte;
    logic [ps2ma_pkg::SUM_W-1:0]       r_sum_x, n_sum_x;
    logic [ps2ma_pkg::SUM_W-1:0]       r_sum_y, n_sum_y;
    logic                              r_have_packet, n_have_packet;
    logic [ps2ma_pkg::BTN_W-1:0]       r_buttons, n_buttons;
    logic [ps2ma_pkg::CURSOR_W-1:0]    r_cursor_x, n_cursor_x;
    logic [ps2ma_pkg::CURSOR_W-1:0]    r_cursor_y, n_cursor_y;
    logic [ps2ma_pkg::GAIN_W-1:0]      r_gain;

    // Result register
    logic                              r_out_valid, n_out_valid;
    logic [ps2ma_pkg::OUT_W-1:0]       r_out_data, n_out_data;

    // Datapath
    logic                              out_free;
    logic                              advance;
    logic [8:0]                        step_x;
    logic [8:0]                        step_y;
    logic [ps2ma_pkg::SUM_W:0]         add_x;
    logic [ps2ma_pkg::SUM_W:0]         add_y;
    logic signed [ps2ma_pkg::DELTA_W-1:0]  delta_x;
    logic signed [ps2ma_pkg::DELTA_W-1:0]  delta_y;
    logic signed [ps2ma_pkg::GAIN_W:0]     gain_s;
    logic signed [ps2ma_pkg::PROD_W-1:0]   prod_x;
    logic signed [ps2ma_pkg::PROD_W-1:0]   prod_y;
    logic signed [ps2ma_pkg::POSSUM_W-1:0] pos_x;
    logic signed [ps2ma_pkg::POSSUM_W-1:0] pos_y;
    logic [ps2ma_pkg::CURSOR_W-1:0]    new_cursor_x;
    logic [ps2ma_pkg::CURSOR_W-1:0]    new_cursor_y;

    // Handshake: the input register moves on whenever the result register can take a word
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= ps2ma_pkg::t_op'(s_axis_tuser);
            r_in_byte <= s_axis_tdata;
        end
    end

    // Gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= ps2ma_pkg::GAIN_RESET;
        end else if (i_cfg_wr_en) begin
            r_gain <= i_cfg_wr_data;
        end
    end

    // Packet movement: nine-bit signed steps added with saturation
    assign step_x = {r_header[ps2ma_pkg::HDR_X_SIGN], r_x_byte};
    assign step_y = {r_header[ps2ma_pkg::HDR_Y_SIGN], r_in_byte};
    assign add_x  = {r_sum_x[ps2ma_pkg::SUM_W-1], r_sum_x} + {{8{step_x[8]}}, step_x};
    assign add_y  = {r_sum_y[ps2ma_pkg::SUM_W-1], r_sum_y} + {{8{step_y[8]}}, step_y};

    // Poll: clamp deltas, scale by gain, move and clamp the cursor
    assign delta_x = ps2ma_pkg::clamp_delta(r_sum_x);
    assign delta_y = ps2ma_pkg::clamp_delta(r_sum_y);
    assign gain_s  = $signed({1'b0, r_gain});
    assign prod_x  = delta_x * gain_s;
    assign prod_y  = delta_y * gain_s;
    assign pos_x   = $signed({{(ps2ma_pkg::POSSUM_W - ps2ma_pkg::CURSOR_W){1'b0}}, r_cursor_x})
                   + $signed({prod_x[ps2ma_pkg::PROD_W-1], prod_x});
    assign pos_y   = $signed({{(ps2ma_pkg::POSSUM_W - ps2ma_pkg::CURSOR_W){1'b0}}, r_cursor_y})
                   - $signed({prod_y[ps2ma_pkg::PROD_W-1], prod_y});
    assign new_cursor_x = ps2ma_pkg::clamp_cursor(pos_x);
    assign new_cursor_y = ps2ma_pkg::clamp_cursor(pos_y);

    // Next state and result
    always_comb begin
        n_phase       = r_phase;
        n_header      = r_header;
        n_x_byte      = r_x_byte;
        n_sum_x       = r_sum_x;
        n_sum_y       = r_sum_y;
        n_have_packet = r_have_packet;
        n_buttons     = r_buttons;
        n_cursor_x    = r_cursor_x;
        n_cursor_y    = r_cursor_y;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_data    = r_out_data;
        if (advance) begin
            if (r_in_op == ps2ma_pkg::OP_BYTE) begin
                case (r_phase)
                    ps2ma_pkg::PH_HEADER: begin
                        n_header = r_in_byte;
                        n_phase  = ps2ma_pkg::PH_X;
                    end
                    ps2ma_pkg::PH_X: begin
                        n_x_byte = r_in_byte;
                        n_phase  = ps2ma_pkg::PH_Y;
                    end
                    ps2ma_pkg::PH_Y: begin
                        n_phase = ps2ma_pkg::PH_HEADER;
                        // drop packets whose header lacks the always-one bit
                        if (r_header[ps2ma_pkg::HDR_ALWAYS_ONE]) begin
                            n_sum_x       = ps2ma_pkg::sat_sum(add_x);
                            n_sum_y       = ps2ma_pkg::sat_sum(add_y);
                            n_buttons     = r_header[ps2ma_pkg::BTN_W-1:0];
                            n_have_packet = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = ps2ma_pkg::PH_HEADER;
                    end
                endcase
            end else if (r_have_packet) begin
                n_cursor_x    = new_cursor_x;
                n_cursor_y    = new_cursor_y;
                n_sum_x       = '0;
                n_sum_y       = '0;
                n_have_packet = 1'b0;
                n_out_valid   = 1'b1;
                n_out_data    = {7'd0, new_cursor_y, new_cursor_x, r_buttons,
                                 delta_y, delta_x};
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ps2ma_pkg::PH_HEADER;
            r_header      <= '0;
            r_x_byte      <= '0;
            r_sum_x       <= '0;
            r_sum_y       <= '0;
            r_have_packet <= 1'b0;
            r_buttons     <= '0;
            r_cursor_x    <= ps2ma_pkg::CURSOR_RESET;
            r_cursor_y    <= ps2ma_pkg::CURSOR_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_header      <= n_header;
            r_x_byte      <= n_x_byte;
            r_sum_x       <= n_sum_x;
            r_sum_y       <= n_sum_y;
            r_have_packet <= n_have_packet;
            r_buttons     <= n_buttons;
            r_cursor_x    <= n_cursor_x;
            r_cursor_y    <= n_cursor_y;
            r_out_valid   <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    // A new result only follows a poll word leaving the input register
    a_result_from_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_in_op == ps2ma_pkg::OP_POLL))
        else $error("result appeared without a poll");

    // A reporting poll clears the pending packet flag
    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == ps2ma_pkg::OP_POLL && r_have_packet) |=> !r_have_packet)
        else $error("packet flag not cleared by poll");

    // A blocked input word is held in place
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_op)))
        else $error("input word lost while stalled");

endmodule

FILE: tb/tb_ps2_mouse_packet_accumulator.sv
// Self-checking testbench for the PS/2 mouse packet accumulator: directed, gain, saturation and random tests.
`timescale 1ns / 100ps

module tb_ps2_mouse_packet_accumulator;

    // Widths and header bits taken from the package
    localparam int BYTE_W         = ps2ma_pkg::BYTE_W;
    localparam int GAIN_W         = ps2ma_pkg::GAIN_W;
    localparam int DELTA_W        = ps2ma_pkg::DELTA_W;
    localparam int BTN_W          = ps2ma_pkg::BTN_W;
    localparam int CURSOR_W       = ps2ma_pkg::CURSOR_W;
    localparam int OUT_W          = ps2ma_pkg::OUT_W;
    localparam int HDR_ALWAYS_ONE = ps2ma_pkg::HDR_ALWAYS_ONE;
    localparam int HDR_X_SIGN     = ps2ma_pkg::HDR_X_SIGN;
    localparam int HDR_Y_SIGN     = ps2ma_pkg::HDR_Y_SIGN;

    // Result word layout, lowest bit first
    localparam int DX_LO  = 0;
    localparam int DY_LO  = DX_LO + DELTA_W;
    localparam int BTN_LO = DY_LO + DELTA_W;
    localparam int PX_LO  = BTN_LO + BTN_W;
    localparam int PY_LO  = PX_LO + CURSOR_W;

    localparam int SUM_MIN    = -32768;
    localparam int SUM_MAX    = 32767;
    localparam int DELTA_MIN  = -128;
    localparam int DELTA_MAX  = 127;
    localparam int CURSOR_TOP = 32767;
    localparam int DRAIN_CYC  = 6;

    typedef struct {
        logic [DELTA_W-1:0]  dx;
        logic [DELTA_W-1:0]  dy;
        logic [BTN_W-1:0]    btn;
        logic [CURSOR_W-1:0] px;
        logic [CURSOR_W-1:0] py;
    } t_mouse_report;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tuser = ps2ma_pkg::OP_BYTE;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                i_cfg_wr_en = 1'b0;
    logic [GAIN_W-1:0]   i_cfg_wr_data = '0;

    // Predicted packet state
    ps2ma_pkg::t_phase   pkt_phase;
    logic [BYTE_W-1:0]   pkt_header;
    logic [BYTE_W-1:0]   pkt_x;
    int                  motion_x;
    int                  motion_y;
    bit                  motion_pending;
    logic [BTN_W-1:0]    kept_btn;
    int                  cursor_x;
    int                  cursor_y;
    int                  gain;

    t_mouse_report       pending_reports[$];
    int                  error_count = 0;
    int                  words_sent = 0;
    int                  burst_left = 0;
    int                  stall_mode = 0;
    int                  stall_cnt = 0;

    ps2_mouse_packet_accumulator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the predicted state by one accepted word; queue a report on a live poll
    task automatic track_mouse_word(input ps2ma_pkg::t_op op, input logic [BYTE_W-1:0] b);
        int sx;
        int sy;
        int dx;
        int dy;
        t_mouse_report rep;
        if (op == ps2ma_pkg::OP_BYTE) begin
            case (pkt_phase)
                ps2ma_pkg::PH_HEADER: begin
                    pkt_header = b;
                    pkt_phase  = ps2ma_pkg::PH_X;
                end
                ps2ma_pkg::PH_X: begin
                    pkt_x     = b;
                    pkt_phase = ps2ma_pkg::PH_Y;
                end
                default: begin
                    pkt_phase = ps2ma_pkg::PH_HEADER;
                    if (pkt_header[HDR_ALWAYS_ONE]) begin
                        sx = pkt_header[HDR_X_SIGN] ? int'(pkt_x) - 256 : int'(pkt_x);
                        sy = pkt_header[HDR_Y_SIGN] ? int'(b) - 256 : int'(b);
                        motion_x       = clamp(motion_x + sx, SUM_MIN, SUM_MAX);
                        motion_y       = clamp(motion_y + sy, SUM_MIN, SUM_MAX);
                        kept_btn       = pkt_header[BTN_W-1:0];
                        motion_pending = 1'b1;
                    end
                end
            endcase
        end else if (motion_pending) begin
            dx       = clamp(motion_x, DELTA_MIN, DELTA_MAX);
            dy       = clamp(motion_y, DELTA_MIN, DELTA_MAX);
            cursor_x = clamp(cursor_x + dx * gain, 0, CURSOR_TOP);
            cursor_y = clamp(cursor_y - dy * gain, 0, CURSOR_TOP);
            motion_x = 0;
            motion_y = 0;
            motion_pending = 1'b0;
            rep.dx  = DELTA_W'(dx);
            rep.dy  = DELTA_W'(dy);
            rep.btn = kept_btn;
            rep.px  = CURSOR_W'(cursor_x);
            rep.py  = CURSOR_W'(cursor_y);
            pending_reports.push_back(rep);
        end
    endtask

    // Offer one word, with random bursts and gaps, and hold it until accepted
    task automatic send_word(input ps2ma_pkg::t_op op, input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= BYTE_W'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        track_mouse_word(op, b);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] x,
                               input logic [BYTE_W-1:0] y);
        send_word(ps2ma_pkg::OP_BYTE, hdr);
        send_word(ps2ma_pkg::OP_BYTE, x);
        send_word(ps2ma_pkg::OP_BYTE, y);
    endtask

    task automatic send_poll();
        send_word(ps2ma_pkg::OP_POLL, BYTE_W'($urandom));
    endtask

    // Drop valid, drain every report, then let the pipeline empty
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= g;
        @(posedge i_clk);
        gain = int'(g);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= GAIN_W'($urandom);
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Random header: flag bit mostly set, signs, buttons and top bits random
    function automatic logic [BYTE_W-1:0] rand_header();
        logic [BYTE_W-1:0] h;
        h = BYTE_W'($urandom);
        h[HDR_ALWAYS_ONE] = ($urandom_range(0, 9) != 0);
        return h;
    endfunction

    // Receiver: stall on a pattern that is picked anew at random from time to time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 64 == 0) begin
                stall_mode <= $urandom_range(0, 3);
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= stall_cnt[0];
            endcase
        end
    end

    // Compare each accepted report word with the oldest prediction
    always @(posedge i_clk) begin
        t_mouse_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report word %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_axis_tdata[DX_LO +: DELTA_W] !== want.dx) begin
                    $display("%0t: delta_x expected %0d actual %0d", $time,
                             $signed(want.dx), $signed(m_axis_tdata[DX_LO +: DELTA_W]));
                    error_count++;
                end
                if (m_axis_tdata[DY_LO +: DELTA_W] !== want.dy) begin
                    $display("%0t: delta_y expected %0d actual %0d", $time,
                             $signed(want.dy), $signed(m_axis_tdata[DY_LO +: DELTA_W]));
                    error_count++;
                end
                if (m_axis_tdata[BTN_LO +: BTN_W] !== want.btn) begin
                    $display("%0t: buttons expected %b actual %b", $time,
                             want.btn, m_axis_tdata[BTN_LO +: BTN_W]);
                    error_count++;
                end
                if (m_axis_tdata[PX_LO +: CURSOR_W] !== want.px) begin
                    $display("%0t: position_x expected %0d actual %0d", $time,
                             want.px, m_axis_tdata[PX_LO +: CURSOR_W]);
                    error_count++;
                end
                if (m_axis_tdata[PY_LO +: CURSOR_W] !== want.py) begin
                    $display("%0t: position_y expected %0d actual %0d", $time,
                             want.py, m_axis_tdata[PY_LO +: CURSOR_W]);
                    error_count++;
                end
            end
        end
    end

    // Field extremes, dropped groups, empty polls, partial group across a poll
    task automatic test_directed();
        send_packet(8'h37, 8'h55, 8'hAA);   // flag bit clear: whole group dropped
        send_poll();                        // nothing pending: no report
        send_packet(8'h0F, 8'hFF, 8'hFF);   // largest positive, clamps to 127
        send_poll();
        send_packet(8'h38, 8'h00, 8'h00);   // most negative, clamps to -128
        send_poll();
        send_packet(8'hFF, 8'hFF, 8'h80);   // all header bits set
        send_poll();
        send_word(ps2ma_pkg::OP_BYTE, 8'h09);   // header, then poll mid-group
        send_poll();
        send_word(ps2ma_pkg::OP_BYTE, 8'h7F);
        send_word(ps2ma_pkg::OP_BYTE, 8'h01);
        send_poll();
        send_poll();                        // already cleared: no report
    endtask

    // Walk the gain through its extremes and push the cursor into both rails
    task automatic test_gain_extremes();
        logic [GAIN_W-1:0] gains[5];
        gains = '{13'd0, 13'd1, 13'd4096, 13'd8191, GAIN_W'($urandom_range(2, 4095))};
        foreach (gains[i]) begin
            write_gain(gains[i]);
            repeat (2) begin
                send_packet({2'b01, 1'b0, 1'b1, 1'b1, BTN_W'($urandom)}, 8'h7F, 8'hFF);
                send_poll();
            end
            repeat (2) begin
                send_packet({2'b10, 1'b1, 1'b0, 1'b1, BTN_W'($urandom)}, 8'h80, 8'h01);
                send_poll();
            end
        end
    endtask

    // Drive X past the top and Y past the bottom of the accumulators before one poll
    task automatic test_accum_saturation();
        logic [1:0] top;
        repeat (130) begin
            top = 2'($urandom);
            send_packet({top, 1'b1, 1'b0, 1'b1, BTN_W'($urandom)}, 8'hFF, 8'h00);
        end
        send_poll();
    endtask

    // Mostly well-formed packets and polls, with stray words and gain changes
    task automatic test_random_traffic(input int n_words);
        int start;
        int next_cfg;
        start    = words_sent;
        next_cfg = words_sent + 200;
        while (words_sent - start < n_words) begin
            if (words_sent >= next_cfg) begin
                // pause until drained, then pick a new gain
                write_gain(($urandom_range(0, 3) == 0) ? GAIN_W'($urandom)
                                                       : GAIN_W'($urandom_range(0, 64)));
                next_cfg = words_sent + 200;
            end
            case ($urandom_range(0, 9))
                0: send_word(ps2ma_pkg::t_op'($urandom_range(0, 1)), BYTE_W'($urandom));
                1, 2: send_poll();
                default: begin
                    send_packet(rand_header(), rand_byte(), rand_byte());
                    if ($urandom_range(0, 1) == 0) send_poll();
                end
            endcase
        end
    endtask

    initial begin
        pkt_phase      = ps2ma_pkg::PH_HEADER;
        pkt_header     = '0;
        pkt_x          = '0;
        motion_x       = 0;
        motion_y       = 0;
        motion_pending = 1'b0;
        kept_btn       = '0;
        cursor_x       = int'(ps2ma_pkg::CURSOR_RESET);
        cursor_y       = int'(ps2ma_pkg::CURSOR_RESET);
        gain           = int'(ps2ma_pkg::GAIN_RESET);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_gain_extremes();
        test_accum_saturation();
        test_random_traffic(350);

        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/ps2ma_pkg.sv
design/ps2_mouse_packet_accumulator.sv
tb/tb_ps2_mouse_packet_accumulator.sv
